// ----- src/text_console_writer_unit_defines.svh -----
// Assertion macros for the text console writer RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef TEXT_CONSOLE_WRITER_UNIT_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TCW_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("text console writer: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define TCW_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("text console writer: next-cycle check failed");

`endif

// ----- src/tcw_pkg.sv -----
// Shared types and constants for the text console writer.
// Depends on nothing; imported by the controller, datapath and top level.
package tcw_pkg;

    // Fixed field widths.
    localparam int CHAR_W = 8;
    localparam int ATTR_W = 8;
    localparam int CELL_W = 16;
    localparam int IDX_W  = 11;
    localparam int POS_W  = 11;

    // Character codes and fill values.
    localparam logic [CHAR_W-1:0] CH_LF       = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR       = 8'h0D;
    localparam logic [CELL_W-1:0] BLANK_CELL  = 16'h0020;
    localparam logic [CELL_W-1:0] ZERO_CELL   = 16'h0000;
    localparam logic [ATTR_W-1:0] ATTR_RESET  = 8'h02;

    // Item modes.
    localparam logic MODE_PUT  = 1'b0;
    localparam logic MODE_READ = 1'b1;

    // Source of a screen store write.
    typedef enum logic [2:0] {
        WR_NONE,
        WR_PUT,
        WR_ZERO,
        WR_BLANK,
        WR_COPY
    } t_wr_sel;

    // Source of a screen store read address.
    typedef enum logic [1:0] {
        RD_NONE,
        RD_CELL,
        RD_SHIFT
    } t_rd_sel;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    latch;
        logic    exec;
        logic    scan_clr;
        logic    scan_inc;
        logic    capture;
        t_wr_sel wr_sel;
        t_rd_sel rd_sel;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_scroll;
        logic scan_copy_end;
        logic scan_last;
    } t_dp_sts;

endpackage

// ----- src/tcw_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port; the data holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/tcw_datapath.sv -----
// Datapath of the text console writer: input latch, cursor, scan counter,
// attribute register, screen store and result registers.
// Depends on tcw_pkg and tcw_ram.
module tcw_datapath
    import tcw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    output t_dp_sts           o_sts,
    input  logic              i_cfg_we,
    input  logic [ATTR_W-1:0] i_cfg_wdata,
    input  logic              i_mode,
    input  logic [CHAR_W-1:0] i_char_code,
    input  logic [IDX_W-1:0]  i_cell_index,
    output logic [POS_W-1:0]  o_cursor_pos,
    output logic [CELL_W-1:0] o_cell_value
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int COL_W = $clog2(COLUMNS);
    localparam int ROW_W = $clog2(ROWS);
    // Wide enough for a cell index, the cell count and the output position.
    localparam int IW    = (AW + 1 > IDX_W) ? AW + 1 : IDX_W;

    localparam logic [COL_W-1:0] LAST_COL      = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0] LAST_ROW      = ROW_W'(ROWS - 1);
    localparam logic [AW-1:0]    SCAN_LAST     = AW'(CELLS - 1);
    localparam logic [AW-1:0]    SCAN_COPY_END = AW'(CELLS - COLUMNS - 1);
    localparam logic [AW-1:0]    ROW_STRIDE    = AW'(COLUMNS);

    logic [ATTR_W-1:0] r_attr;
    logic              r_mode;
    logic [CHAR_W-1:0] r_ch;
    logic [IW-1:0]     r_idx;
    logic [COL_W-1:0]  r_col;
    logic [ROW_W-1:0]  r_row;
    logic [AW-1:0]     r_scan;
    logic [POS_W-1:0]  r_cursor_pos;
    logic [CELL_W-1:0] r_cell_value;

    logic [IW-1:0]     pos_w;
    logic              in_range;
    logic              is_lf;
    logic              is_cr;
    logic              is_print;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [CELL_W-1:0] ram_wdata;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [CELL_W-1:0] ram_rdata;

    // Decode of the latched item.
    assign is_lf    = (r_mode == MODE_PUT) && (r_ch == CH_LF);
    assign is_cr    = (r_mode == MODE_PUT) && (r_ch == CH_CR);
    assign is_print = (r_mode == MODE_PUT) && !is_lf && !is_cr;
    assign in_range = r_idx < IW'(CELLS);

    // Linear cursor position.
    assign pos_w = IW'(r_row) * IW'(COLUMNS) + IW'(r_col);

    // A scroll follows when the row would move past the last one.
    assign o_sts.need_scroll   = (r_row == LAST_ROW) &&
                                 (is_lf || (is_print && (r_col == LAST_COL)));
    assign o_sts.scan_copy_end = (r_scan == SCAN_COPY_END);
    assign o_sts.scan_last     = (r_scan == SCAN_LAST);

    // Attribute register, written through the configuration port.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr <= ATTR_RESET;
        end else if (i_cfg_we) begin
            r_attr <= i_cfg_wdata;
        end
    end

    // Input latch at the transfer of an item.
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_mode <= i_mode;
            r_ch   <= i_char_code;
            r_idx  <= IW'(i_cell_index);
        end
    end

    // Cursor update for put items.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_cmd.exec) begin
            if (is_lf) begin
                if (r_row != LAST_ROW) begin
                    r_row <= r_row + 1'b1;
                end
            end else if (is_cr) begin
                r_col <= '0;
            end else if (is_print) begin
                if (r_col == LAST_COL) begin
                    r_col <= '0;
                    if (r_row != LAST_ROW) begin
                        r_row <= r_row + 1'b1;
                    end
                end else begin
                    r_col <= r_col + 1'b1;
                end
            end
        end
    end

    // Scan counter for the clearing pass and the scroll.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan <= '0;
        end else if (i_cmd.scan_clr) begin
            r_scan <= '0;
        end else if (i_cmd.scan_inc) begin
            r_scan <= r_scan + 1'b1;
        end
    end

    // Write port selection.
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_scan;
        ram_wdata = ZERO_CELL;
        case (i_cmd.wr_sel)
            WR_PUT: begin
                ram_we    = is_print;
                ram_waddr = pos_w[AW-1:0];
                ram_wdata = {r_attr, r_ch};
            end
            WR_ZERO: begin
                ram_we    = 1'b1;
                ram_wdata = ZERO_CELL;
            end
            WR_BLANK: begin
                ram_we    = 1'b1;
                ram_wdata = BLANK_CELL;
            end
            WR_COPY: begin
                ram_we    = 1'b1;
                ram_wdata = ram_rdata;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    // Read port selection.
    always_comb begin
        ram_re    = 1'b0;
        ram_raddr = r_scan + ROW_STRIDE;
        case (i_cmd.rd_sel)
            RD_CELL: begin
                ram_re    = (r_mode == MODE_READ);
                ram_raddr = r_idx[AW-1:0];
            end
            RD_SHIFT: begin
                ram_re = 1'b1;
            end
            default: begin
                ram_re = 1'b0;
            end
        endcase
    end

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_screen (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Result registers, loaded when the item finishes.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cursor_pos <= pos_w[POS_W-1:0];
            if ((r_mode == MODE_READ) && in_range) begin
                r_cell_value <= ram_rdata;
            end else begin
                r_cell_value <= ZERO_CELL;
            end
        end
    end

    assign o_cursor_pos = r_cursor_pos;
    assign o_cell_value = r_cell_value;

endmodule

// ----- src/tcw_ctrl.sv -----
// Controller of the text console writer: sequences items, the clearing pass
// after reset and the scroll. Depends on tcw_pkg and the assertion macros.
`include "text_console_writer_unit_defines.svh"

module tcw_ctrl
    import tcw_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    output logic    o_busy,
    output logic    o_done,
    output t_dp_cmd o_cmd,
    input  t_dp_sts i_sts
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_SCR_RD,
        S_SCR_WR,
        S_FILL,
        S_FIN
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_busy;
    logic   r_done;

    // Next state and datapath commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '{latch: 1'b0, exec: 1'b0, scan_clr: 1'b0, scan_inc: 1'b0,
                    capture: 1'b0, wr_sel: WR_NONE, rd_sel: RD_NONE};
        case (r_state)
            S_CLEAR: begin
                o_cmd.wr_sel   = WR_ZERO;
                o_cmd.scan_inc = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start && !r_busy) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec   = 1'b1;
                o_cmd.wr_sel = WR_PUT;
                o_cmd.rd_sel = RD_CELL;
                if (i_sts.need_scroll) begin
                    o_cmd.scan_clr = 1'b1;
                    n_state        = S_SCR_RD;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_SCR_RD: begin
                o_cmd.rd_sel = RD_SHIFT;
                n_state      = S_SCR_WR;
            end
            S_SCR_WR: begin
                o_cmd.wr_sel   = WR_COPY;
                o_cmd.scan_inc = 1'b1;
                n_state        = i_sts.scan_copy_end ? S_FILL : S_SCR_RD;
            end
            S_FILL: begin
                o_cmd.wr_sel   = WR_BLANK;
                o_cmd.scan_inc = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                o_cmd.capture = 1'b1;
                n_state       = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered handshake outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_busy  <= 1'b1;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= (n_state != S_IDLE);
            r_done  <= (r_state == S_FIN);
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;

    // The busy flag mirrors the state, so a transfer only starts from idle.
    `TCW_ASSERT_IMP(a_busy_matches_state, i_clk, i_rst_n, 1'b1, r_busy == (r_state != S_IDLE))
    // A transferred item goes straight into execution.
    `TCW_ASSERT_NXT(a_start_to_exec, i_clk, i_rst_n, i_start && !r_busy, r_state == S_EXEC)
    // Each result strobe follows the finishing state and lands in idle.
    `TCW_ASSERT_IMP(a_done_after_fin, i_clk, i_rst_n, r_done, $past(r_state) == S_FIN && r_state == S_IDLE)
    // The end of the row copy hands over to the fill of the last row.
    `TCW_ASSERT_NXT(a_copy_to_fill, i_clk, i_rst_n, r_state == S_SCR_WR && i_sts.scan_copy_end, r_state == S_FILL)

endmodule

// ----- src/text_console_writer_unit.sv -----
// Text console writer: top level joining the controller and the datapath.
// Depends on tcw_pkg, tcw_ctrl and tcw_datapath.
//
// Usage:
//   An item (mode, char_code, cell_index) is transferred at a rising edge with
//   start high and busy low. Mode 0 puts a character at the cursor (line feed,
//   carriage return or a printable byte); mode 1 reads one screen cell.
//   Exactly one result follows each item: o_done is high for one cycle while
//   o_cursor_pos and o_cell_value hold it. The receiver cannot stall; the
//   result is taken in that cycle.
//   Sequence: the item passes through S_EXEC and S_FIN, then o_done rises and
//   busy falls at the same edge, so a new item is taken only after the last
//   one's result is out. A put that moves past the last row also scrolls the
//   screen store, which has one read and one write port: each copied cell takes
//   a read and then a write, each blank cell a write, and busy stays high.
//   Reset: the cursor returns to the top left and the attribute to 2; then a
//   clearing pass writes zero to every cell, one per cycle, with busy held high.
//   The attribute is written through i_cfg_we and i_cfg_wdata; the user must
//   write it only while the block is idle, which the block does not enforce.
module text_console_writer_unit
    import tcw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              i_mode,
    input  logic [CHAR_W-1:0] i_char_code,
    input  logic [IDX_W-1:0]  i_cell_index,
    input  logic              i_cfg_we,
    input  logic [ATTR_W-1:0] i_cfg_wdata,
    output logic              o_done,
    output logic [POS_W-1:0]  o_cursor_pos,
    output logic [CELL_W-1:0] o_cell_value
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    // Sequencing.
    tcw_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_done  (o_done),
        .o_cmd   (dp_cmd),
        .i_sts   (dp_sts)
    );

    // Cursor, screen store and result registers.
    tcw_datapath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (dp_cmd),
        .o_sts        (dp_sts),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_mode       (i_mode),
        .i_char_code  (i_char_code),
        .i_cell_index (i_cell_index),
        .o_cursor_pos (o_cursor_pos),
        .o_cell_value (o_cell_value)
    );

endmodule

// ----- tb/text_console_writer_unit_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the text console writer: a behavioural screen model
// predicts every result, which is compared field by field as it leaves the block.
// Depends on tcw_pkg and text_console_writer_unit.
module text_console_writer_unit_tb;
    import tcw_pkg::*;

    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELLS      = COLUMNS * ROWS;
    localparam int STALL_MAX  = 20000;
    localparam int PRINT_MAX  = 200;

    typedef struct {
        logic [POS_W-1:0]  pos;
        logic [CELL_W-1:0] cell_val;
    } t_console_result;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic              i_mode;
    logic [CHAR_W-1:0] i_char_code;
    logic [IDX_W-1:0]  i_cell_index;
    logic              i_cfg_we;
    logic [ATTR_W-1:0] i_cfg_wdata;
    logic              o_done;
    logic [POS_W-1:0]  o_cursor_pos;
    logic [CELL_W-1:0] o_cell_value;

    // Screen model state and the queue of results still to come.
    logic [CELL_W-1:0] shadow_screen [CELLS];
    int                cur_col;
    int                cur_row;
    logic [ATTR_W-1:0] text_attr;
    t_console_result   pending_results [$];
    int                error_count = 0;
    int                stall_cycles = 0;

    text_console_writer_unit #(
        .COLUMNS(COLUMNS),
        .ROWS   (ROWS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_mode      (i_mode),
        .i_char_code (i_char_code),
        .i_cell_index(i_cell_index),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_done      (o_done),
        .o_cursor_pos(o_cursor_pos),
        .o_cell_value(o_cell_value)
    );

    // Free-running clock, 2 ns period.
    always #1 i_clk = ~i_clk;

    task automatic report_mismatch(input string what, input int got, input int want);
        error_count++;
        if (error_count <= PRINT_MAX) begin
            $display("%0t ns: %s: got 'h%0h, expected 'h%0h", $realtime, what, got, want);
        end
    endtask

    // Move the cursor down a row; past the bottom the screen scrolls up by one row.
    task automatic advance_row();
        cur_row++;
        if (cur_row >= ROWS) begin
            for (int i = 0; i < CELLS - COLUMNS; i++) begin
                shadow_screen[i] = shadow_screen[i + COLUMNS];
            end
            for (int i = CELLS - COLUMNS; i < CELLS; i++) begin
                shadow_screen[i] = BLANK_CELL;
            end
            cur_row = ROWS - 1;
        end
    endtask

    // Apply one transferred item to the screen model and queue its result.
    task automatic predict_item(input logic mode, input logic [CHAR_W-1:0] ch,
                                input logic [IDX_W-1:0] idx);
        t_console_result res;
        res.cell_val = ZERO_CELL;
        if (mode == MODE_READ) begin
            if (idx < CELLS) res.cell_val = shadow_screen[idx];
        end else if (ch == CH_LF) begin
            advance_row();
        end else if (ch == CH_CR) begin
            cur_col = 0;
        end else begin
            shadow_screen[cur_row * COLUMNS + cur_col] = {text_attr, ch};
            cur_col++;
            if (cur_col >= COLUMNS) begin
                cur_col = 0;
                advance_row();
            end
        end
        res.pos = POS_W'(cur_row * COLUMNS + cur_col);
        pending_results.push_back(res);
    endtask

    // Present one item and hold it until the block takes it.
    task automatic send_item(input logic mode, input logic [CHAR_W-1:0] ch,
                             input logic [IDX_W-1:0] idx);
        @(negedge i_clk);
        start        <= 1'b1;
        i_mode       <= mode;
        i_char_code  <= ch;
        i_cell_index <= idx;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        predict_item(mode, ch, idx);
    endtask

    task automatic idle_cycles(input int n);
        repeat (n) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
    endtask

    // Hold off until every queued result has arrived and the block is idle.
    task automatic wait_drained();
        idle_cycles(1);
        @(posedge i_clk);
        while (pending_results.size() != 0 || busy) @(posedge i_clk);
    endtask

    task automatic write_attribute(input logic [ATTR_W-1:0] value);
        wait_drained();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        text_attr = value;
    endtask

    // A freshly cleared screen reads back as zero and the cursor sits at the top left.
    task automatic test_reset_contents();
        send_item(MODE_READ, 8'h00, 11'd0);
        send_item(MODE_READ, 8'hFF, 11'd1999);
    endtask

    // Byte extremes, both control codes and a blank.
    task automatic test_put_codes();
        send_item(MODE_PUT, 8'h00, 11'd0);
        send_item(MODE_PUT, 8'hFF, 11'h7FF);
        send_item(MODE_PUT, 8'h80, 11'd0);
        send_item(MODE_PUT, 8'h41, 11'd5);
        send_item(MODE_PUT, 8'h7F, 11'd0);
        send_item(MODE_PUT, CH_CR, 11'd0);
        send_item(MODE_PUT, CH_LF, 11'd0);
        send_item(MODE_PUT, 8'h20, 11'd0);
    endtask

    // Reads of written cells, of an unwritten cell and beyond the end of the screen.
    task automatic test_cell_reads();
        send_item(MODE_READ, 8'h00, 11'd0);
        send_item(MODE_READ, 8'hFF, 11'd1);
        send_item(MODE_READ, CH_LF, 11'd2000);
        send_item(MODE_READ, CH_CR, 11'h7FF);
        send_item(MODE_READ, 8'h00, 11'd1024);
    endtask

    // Both attribute extremes reach the high byte of a written cell.
    task automatic test_attribute_writes();
        write_attribute(8'h00);
        send_item(MODE_PUT, 8'h61, 11'd0);
        write_attribute(8'hFF);
        send_item(MODE_PUT, 8'h62, 11'd0);
        send_item(MODE_READ, 8'h00, 11'(COLUMNS + 1));
        send_item(MODE_READ, 8'h00, 11'(COLUMNS + 2));
    endtask

    // Mostly text with line endings, so the cursor wraps and the screen scrolls,
    // mixed with reads aimed at the whole store and at the newest cells.
    task automatic test_random_traffic(input int n, input bit with_idle);
        int                sel;
        int                pos;
        logic [IDX_W-1:0]  idx;
        logic [CHAR_W-1:0] ch;
        for (int k = 0; k < n; k++) begin
            sel = $urandom_range(0, 99);
            idx = IDX_W'($urandom_range(0, 2047));
            ch  = CHAR_W'($urandom_range(0, 255));
            if (sel < 18) begin
                pos = cur_row * COLUMNS + cur_col;
                case ($urandom_range(0, 3))
                    0: idx = IDX_W'($urandom_range(0, 2047));
                    1: idx = IDX_W'($urandom_range(0, CELLS - 1));
                    2: idx = IDX_W'(CELLS - COLUMNS + $urandom_range(0, COLUMNS - 1));
                    default: idx = IDX_W'((pos > 0) ? pos - 1 : 0);
                endcase
                send_item(MODE_READ, ch, idx);
            end else if (sel < 26) begin
                send_item(MODE_PUT, CH_LF, idx);
            end else if (sel < 30) begin
                send_item(MODE_PUT, CH_CR, idx);
                send_item(MODE_PUT, CH_LF, idx);
            end else begin
                send_item(MODE_PUT, ch, idx);
            end
            if (with_idle && $urandom_range(0, 3) == 0) idle_cycles($urandom_range(1, 16));
            if (k == n / 2) wait_drained();
        end
    endtask

    // Result checker: every strobe must match the oldest outstanding prediction.
    always @(posedge i_clk) begin
        t_console_result want;
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing outstanding", o_cursor_pos, 0);
            end else begin
                want = pending_results.pop_front();
                if (o_cursor_pos !== want.pos)
                    report_mismatch("cursor_pos", o_cursor_pos, want.pos);
                if (o_cell_value !== want.cell_val)
                    report_mismatch("cell_value", o_cell_value, want.cell_val);
            end
        end
    end

    // Watchdog: too long without a transfer or a result ends the run.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_MAX) begin
            $display("Watchdog: no transfer for %0d cycles", stall_cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Test sequence.
    initial begin
        start        = 1'b0;
        i_mode       = MODE_PUT;
        i_char_code  = '0;
        i_cell_index = '0;
        i_cfg_we     = 1'b0;
        i_cfg_wdata  = '0;
        i_rst_n      = 1'b0;
        for (int i = 0; i < CELLS; i++) shadow_screen[i] = ZERO_CELL;
        cur_col   = 0;
        cur_row   = 0;
        text_attr = ATTR_RESET;

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        wait_drained();

        test_reset_contents();
        test_put_codes();
        test_cell_reads();
        test_attribute_writes();

        write_attribute(ATTR_W'($urandom_range(1, 254)));
        test_random_traffic(290, 1'b1);
        write_attribute(8'hFF);
        test_random_traffic(290, 1'b1);
        write_attribute(8'h00);
        test_random_traffic(220, 1'b0);

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
